/* rtl/core/bpc_pkg.sv */
// Shared types, constants and helpers for the pressure compensation pipeline.
package bpc_pkg;

  localparam int unsigned DivW    = 32;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgW    = 64;

  typedef enum logic [CfgIdxW-1:0] {
    CfgGroupA = 2'd0,
    CfgGroupB = 2'd1,
    CfgGroupC = 2'd2,
    CfgOss    = 2'd3
  } cfg_idx_e;

  localparam logic [31:0] TempOffset = 32'd4000;
  localparam logic [31:0] B4Bias     = 32'd32768;
  localparam logic [31:0] PresScale  = 32'd50000;
  localparam logic [31:0] CoefSq     = 32'd3038;
  localparam logic [31:0] CoefLin    = 32'hFFFF_E343;  // -7357
  localparam logic [31:0] CoefOff    = 32'd3791;
  localparam logic [19:0] PresMax    = 20'hF_FFFF;

  function automatic logic [31:0] sx16(logic [15:0] v);
    return {{16{v[15]}}, v};
  endfunction

  function automatic logic [31:0] asr32(logic [31:0] v, logic [4:0] s);
    return 32'($signed(v) >>> s);
  endfunction

endpackage

/* rtl/core/bpc_div.sv */
// Pipelined unsigned 32-bit restoring divider, one quotient bit per stage.
module bpc_div #(
  parameter int unsigned PayloadW = 1
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  input  logic [31:0]         dividend_i,
  input  logic [31:0]         divisor_i,
  input  logic [PayloadW-1:0] payload_i,
  output logic                valid_o,
  output logic [31:0]         quotient_o,
  output logic [PayloadW-1:0] payload_o
);

  localparam int unsigned Steps = bpc_pkg::DivW;

  logic                vld_q [Steps];
  logic [31:0]         rem_q [Steps];
  logic [31:0]         acc_q [Steps];
  logic [31:0]         dvs_q [Steps];
  logic [PayloadW-1:0] pay_q [Steps];

  for (genvar k = 0; k < Steps; k++) begin : g_step
    logic                vld_in;
    logic [31:0]         rem_in;
    logic [31:0]         acc_in;
    logic [31:0]         dvs_in;
    logic [PayloadW-1:0] pay_in;
    logic [32:0]         trial;
    logic [32:0]         diff;

    if (k == 0) begin : g_first
      assign vld_in = valid_i;
      assign rem_in = '0;
      assign acc_in = dividend_i;
      assign dvs_in = divisor_i;
      assign pay_in = payload_i;
    end else begin : g_rest
      assign vld_in = vld_q[k-1];
      assign rem_in = rem_q[k-1];
      assign acc_in = acc_q[k-1];
      assign dvs_in = dvs_q[k-1];
      assign pay_in = pay_q[k-1];
    end

    assign trial = {rem_in, acc_in[31]};
    assign diff  = trial - {1'b0, dvs_in};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else begin
        vld_q[k] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      rem_q[k] <= diff[32] ? trial[31:0] : diff[31:0];
      acc_q[k] <= {acc_in[30:0], ~diff[32]};
      dvs_q[k] <= dvs_in;
      pay_q[k] <= pay_in;
    end
  end

  assign valid_o    = vld_q[Steps-1];
  assign quotient_o = acc_q[Steps-1];
  assign payload_o  = pay_q[Steps-1];

endmodule

/* rtl/core/barometric_pressure_compensation.sv */
// A result strobes on done_o after S1-S2, divider 1, S3-S8, divider 2 and S9-S11.
// Throughput: one request per cycle; busy_o stays low, nothing ever stalls.
// Latency is set by two 32-stage divider pipelines plus eleven arithmetic stages.
// Reset (rst_ni low, async) clears valid bits and zeroes all calibration regs.
// The receiver cannot stall: results are simply presented for one cycle.
module barometric_pressure_compensation (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  output logic                              busy_o,
  input  logic [15:0]                       raw_temperature_i,
  input  logic [23:0]                       raw_pressure_i,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [bpc_pkg::CfgIdxW-1:0]       cfg_index_i,
  input  logic [bpc_pkg::CfgW-1:0]          cfg_data_i,
  output logic                              done_o,
  output logic signed [15:0]                temperature_tenths_o,
  output logic [19:0]                       pressure_pa_o,
  output logic                              divide_fault_o
);

  // ---------------------------------------------------------------
  // Calibration registers (the user is to write them only while the pipe is empty; the block does not enforce it)
  // ---------------------------------------------------------------
  logic [63:0] cal_a_q, cal_b_q;
  logic [31:0] cal_c_q;
  logic [1:0]  oss_q;

  assign cfg_ready_o = 1'b1;
  assign busy_o      = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cal_a_q <= '0;
      cal_b_q <= '0;
      cal_c_q <= '0;
      oss_q   <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        bpc_pkg::CfgGroupA: cal_a_q <= cfg_data_i;
        bpc_pkg::CfgGroupB: cal_b_q <= cfg_data_i;
        bpc_pkg::CfgGroupC: cal_c_q <= cfg_data_i[31:0];
        bpc_pkg::CfgOss:    oss_q   <= cfg_data_i[1:0];
        default: ;
      endcase
    end
  end

  logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
  assign ac1 = bpc_pkg::sx16(cal_a_q[15:0]);
  assign ac2 = bpc_pkg::sx16(cal_a_q[31:16]);
  assign ac3 = bpc_pkg::sx16(cal_a_q[47:32]);
  assign ac4 = {16'b0, cal_a_q[63:48]};
  assign ac5 = {16'b0, cal_b_q[15:0]};
  assign ac6 = {16'b0, cal_b_q[31:16]};
  assign b1  = bpc_pkg::sx16(cal_b_q[47:32]);
  assign b2  = bpc_pkg::sx16(cal_b_q[63:48]);
  assign mc  = bpc_pkg::sx16(cal_c_q[15:0]);
  assign md  = bpc_pkg::sx16(cal_c_q[31:16]);

  logic start_ok;
  assign start_ok = start_i && !busy_o;

  // ---------------------------------------------------------------
  // Valid chain (reset) for the arithmetic stages
  // ---------------------------------------------------------------
  logic s1_vld_q, s2_vld_q, s3_vld_q, s4_vld_q, s5_vld_q, s6_vld_q;
  logic s7_vld_q, s8_vld_q, s9_vld_q, s10_vld_q, out_vld_q;
  logic d1_vld, d2_vld;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      s2_vld_q  <= 1'b0;
      s3_vld_q  <= 1'b0;
      s4_vld_q  <= 1'b0;
      s5_vld_q  <= 1'b0;
      s6_vld_q  <= 1'b0;
      s7_vld_q  <= 1'b0;
      s8_vld_q  <= 1'b0;
      s9_vld_q  <= 1'b0;
      s10_vld_q <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      s1_vld_q  <= start_ok;
      s2_vld_q  <= s1_vld_q;
      s3_vld_q  <= d1_vld;
      s4_vld_q  <= s3_vld_q;
      s5_vld_q  <= s4_vld_q;
      s6_vld_q  <= s5_vld_q;
      s7_vld_q  <= s6_vld_q;
      s8_vld_q  <= s7_vld_q;
      s9_vld_q  <= d2_vld;
      s10_vld_q <= s9_vld_q;
      out_vld_q <= s10_vld_q;
    end
  end

  // ---------------------------------------------------------------
  // S1: (ut - ac6) * ac5
  // ---------------------------------------------------------------
  logic [31:0] s1_prod_q;
  logic [23:0] s1_up_q;
  always_ff @(posedge clk_i) begin
    s1_prod_q <= ({16'b0, raw_temperature_i} - ac6) * ac5;
    s1_up_q   <= raw_pressure_i;
  end

  // ---------------------------------------------------------------
  // S2: x1, temperature divisor, sign/magnitude split for divider 1
  // ---------------------------------------------------------------
  logic [31:0] s2_x1, s2_den, s2_num;
  assign s2_x1  = bpc_pkg::asr32(s1_prod_q, 5'd15);
  assign s2_den = s2_x1 + md;
  assign s2_num = {mc[20:0], 11'b0};

  logic [31:0] s2_x1_q, s2_nmag_q, s2_dmag_q;
  logic [23:0] s2_up_q;
  logic        s2_neg_q, s2_fault_q;
  always_ff @(posedge clk_i) begin
    s2_x1_q    <= s2_x1;
    s2_nmag_q  <= s2_num[31] ? (32'd0 - s2_num) : s2_num;
    s2_dmag_q  <= s2_den[31] ? (32'd0 - s2_den) : s2_den;
    s2_neg_q   <= s2_num[31] ^ s2_den[31];
    s2_fault_q <= (s2_den == 32'd0);
    s2_up_q    <= s1_up_q;
  end

  // Divider 1: mc*2048 / (x1 + md); payload {fault, neg, up, x1}
  localparam int unsigned Pay1W = 1 + 1 + 24 + 32;
  logic [31:0]      d1_q;
  logic [Pay1W-1:0] d1_pay;

  bpc_div #(.PayloadW(Pay1W)) u_div_temp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (s2_vld_q),
    .dividend_i (s2_nmag_q),
    .divisor_i  (s2_dmag_q),
    .payload_i  ({s2_fault_q, s2_neg_q, s2_up_q, s2_x1_q}),
    .valid_o    (d1_vld),
    .quotient_o (d1_q),
    .payload_o  (d1_pay)
  );

  // ---------------------------------------------------------------
  // S3: b5, saturated temperature, b6
  // ---------------------------------------------------------------
  logic [31:0] s3_x2, s3_b5, s3_t;
  assign s3_x2 = d1_pay[56] ? (32'd0 - d1_q) : d1_q;
  assign s3_b5 = d1_pay[31:0] + s3_x2;
  assign s3_t  = bpc_pkg::asr32(s3_b5 + 32'd8, 5'd4);

  logic [15:0] s3_t_q;
  logic [31:0] s3_b6_q;
  logic [23:0] s3_up_q;
  logic        s3_fault_q;
  always_ff @(posedge clk_i) begin
    if ($signed(s3_t) > 32'sd32767) begin
      s3_t_q <= 16'h7FFF;
    end else if ($signed(s3_t) < -32'sd32768) begin
      s3_t_q <= 16'h8000;
    end else begin
      s3_t_q <= s3_t[15:0];
    end
    s3_b6_q    <= s3_b5 - bpc_pkg::TempOffset;
    s3_up_q    <= d1_pay[55:32];
    s3_fault_q <= d1_pay[57];
  end

  // ---------------------------------------------------------------
  // S4: b6*b6, ac2*b6, ac3*b6
  // ---------------------------------------------------------------
  logic [31:0] s4_sq_q, s4_a2_q, s4_a3_q;
  logic [15:0] s4_t_q;
  logic [23:0] s4_up_q;
  logic        s4_fault_q;
  always_ff @(posedge clk_i) begin
    s4_sq_q    <= s3_b6_q * s3_b6_q;
    s4_a2_q    <= ac2 * s3_b6_q;
    s4_a3_q    <= ac3 * s3_b6_q;
    s4_t_q     <= s3_t_q;
    s4_up_q    <= s3_up_q;
    s4_fault_q <= s3_fault_q;
  end

  // ---------------------------------------------------------------
  // S5: b2*sq, b1*sq
  // ---------------------------------------------------------------
  logic [31:0] s5_sq;
  assign s5_sq = bpc_pkg::asr32(s4_sq_q, 5'd12);

  logic [31:0] s5_b2sq_q, s5_b1sq_q, s5_a2_q, s5_a3_q;
  logic [15:0] s5_t_q;
  logic [23:0] s5_up_q;
  logic        s5_fault_q;
  always_ff @(posedge clk_i) begin
    s5_b2sq_q  <= b2 * s5_sq;
    s5_b1sq_q  <= b1 * s5_sq;
    s5_a2_q    <= s4_a2_q;
    s5_a3_q    <= s4_a3_q;
    s5_t_q     <= s4_t_q;
    s5_up_q    <= s4_up_q;
    s5_fault_q <= s4_fault_q;
  end

  // ---------------------------------------------------------------
  // S6: b3 (signed /4 truncating) and x3 for b4
  // ---------------------------------------------------------------
  logic [31:0] s6_x3, s6_v, s6_y3;
  assign s6_x3 = bpc_pkg::asr32(s5_b2sq_q, 5'd11) + bpc_pkg::asr32(s5_a2_q, 5'd11);
  assign s6_v  = (({ac1[29:0], 2'b00} + s6_x3) << oss_q) + 32'd2;
  assign s6_y3 = bpc_pkg::asr32(bpc_pkg::asr32(s5_a3_q, 5'd13)
                 + bpc_pkg::asr32(s5_b1sq_q, 5'd16) + 32'd2, 5'd2);

  logic [31:0] s6_b3_q, s6_x3_q;
  logic [15:0] s6_t_q;
  logic [23:0] s6_up_q;
  logic        s6_fault_q;
  always_ff @(posedge clk_i) begin
    // round toward zero: bias negatives by 3 before the arithmetic shift
    s6_b3_q    <= bpc_pkg::asr32(s6_v + (s6_v[31] ? 32'd3 : 32'd0), 5'd2);
    s6_x3_q    <= s6_y3;
    s6_t_q     <= s5_t_q;
    s6_up_q    <= s5_up_q;
    s6_fault_q <= s5_fault_q;
  end

  // ---------------------------------------------------------------
  // S7: ac4*(x3+32768), shifted raw pressure minus b3
  // ---------------------------------------------------------------
  logic [3:0] s7_shamt;
  assign s7_shamt = 4'd8 - {2'b00, oss_q};

  logic [31:0] s7_b4p_q, s7_b7a_q;
  logic [15:0] s7_t_q;
  logic        s7_fault_q;
  always_ff @(posedge clk_i) begin
    s7_b4p_q   <= ac4 * (s6_x3_q + bpc_pkg::B4Bias);
    s7_b7a_q   <= ({8'b0, s6_up_q} >> s7_shamt) - s6_b3_q;
    s7_t_q     <= s6_t_q;
    s7_fault_q <= s6_fault_q;
  end

  // ---------------------------------------------------------------
  // S8: b4, b7 and the doubled-or-not dividend for divider 2
  // ---------------------------------------------------------------
  logic [31:0] s8_b4, s8_b7;
  assign s8_b4 = s7_b4p_q >> 15;
  assign s8_b7 = s7_b7a_q * (bpc_pkg::PresScale >> oss_q);

  logic [31:0] s8_num_q, s8_b4_q;
  logic [15:0] s8_t_q;
  logic        s8_post2_q, s8_fault_q;
  always_ff @(posedge clk_i) begin
    s8_num_q   <= s8_b7[31] ? s8_b7 : {s8_b7[30:0], 1'b0};
    s8_post2_q <= s8_b7[31];
    s8_b4_q    <= s8_b4;
    s8_fault_q <= s7_fault_q || (s8_b4 == 32'd0);
    s8_t_q     <= s7_t_q;
  end

  // Divider 2: b7 / b4; payload {fault, post-double, temperature}
  localparam int unsigned Pay2W = 1 + 1 + 16;
  logic [31:0]      d2_q;
  logic [Pay2W-1:0] d2_pay;

  bpc_div #(.PayloadW(Pay2W)) u_div_pres (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (s8_vld_q),
    .dividend_i (s8_num_q),
    .divisor_i  (s8_b4_q),
    .payload_i  ({s8_fault_q, s8_post2_q, s8_t_q}),
    .valid_o    (d2_vld),
    .quotient_o (d2_q),
    .payload_o  (d2_pay)
  );

  // ---------------------------------------------------------------
  // S9: p, (p>>8)^2, -7357*p
  // ---------------------------------------------------------------
  logic [31:0] s9_p, s9_xs;
  assign s9_p  = d2_pay[16] ? {d2_q[30:0], 1'b0} : d2_q;
  assign s9_xs = bpc_pkg::asr32(s9_p, 5'd8);

  logic [31:0] s9_p_q, s9_sqx_q, s9_m7_q;
  logic [15:0] s9_t_q;
  logic        s9_fault_q;
  always_ff @(posedge clk_i) begin
    s9_p_q     <= s9_p;
    s9_sqx_q   <= s9_xs * s9_xs;
    s9_m7_q    <= bpc_pkg::CoefLin * s9_p;
    s9_t_q     <= d2_pay[15:0];
    s9_fault_q <= d2_pay[17];
  end

  // ---------------------------------------------------------------
  // S10: x1 * 3038
  // ---------------------------------------------------------------
  logic [31:0] s10_m3_q, s10_p_q, s10_m7_q;
  logic [15:0] s10_t_q;
  logic        s10_fault_q;
  always_ff @(posedge clk_i) begin
    s10_m3_q    <= s9_sqx_q * bpc_pkg::CoefSq;
    s10_p_q     <= s9_p_q;
    s10_m7_q    <= s9_m7_q;
    s10_t_q     <= s9_t_q;
    s10_fault_q <= s9_fault_q;
  end

  // ---------------------------------------------------------------
  // S11: final correction, saturation, fault zeroing
  // ---------------------------------------------------------------
  logic [31:0] s11_pres;
  assign s11_pres = s10_p_q + bpc_pkg::asr32(bpc_pkg::asr32(s10_m3_q, 5'd16)
                    + bpc_pkg::asr32(s10_m7_q, 5'd16) + bpc_pkg::CoefOff, 5'd4);

  logic [15:0] out_t_q;
  logic [19:0] out_p_q;
  logic        out_fault_q;
  always_ff @(posedge clk_i) begin
    out_fault_q <= s10_fault_q;
    if (s10_fault_q) begin
      out_t_q <= '0;
      out_p_q <= '0;
    end else begin
      out_t_q <= s10_t_q;
      if (s11_pres[31]) begin
        out_p_q <= '0;
      end else if (s11_pres[30:20] != 11'd0) begin
        out_p_q <= bpc_pkg::PresMax;
      end else begin
        out_p_q <= s11_pres[19:0];
      end
    end
  end

  assign done_o               = out_vld_q;
  assign temperature_tenths_o = out_t_q;
  assign pressure_pa_o        = out_p_q;
  assign divide_fault_o       = out_fault_q;

`ifndef ASSERT_OFF
  a_fixed_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_ok |-> ##75 done_o)
    else $error("request did not complete at the fixed latency");

  a_fault_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && divide_fault_o) |-> (temperature_tenths_o == 16'd0 && pressure_pa_o == 20'd0))
    else $error("fault result carries nonzero data");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    d2_vld |-> $past(s8_vld_q, 32))
    else $error("divider produced a result with no request");
`endif

endmodule

/* test/bpc_checker.sv */
// Checker for the pressure compensation block: predicts each result and compares.
`timescale 1ns / 1ps
module bpc_checker (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  input  logic         busy_i,
  input  logic [15:0]  raw_temperature_i,
  input  logic [23:0]  raw_pressure_i,
  input  logic         cfg_valid_i,
  input  logic         cfg_ready_i,
  input  logic [1:0]   cfg_index_i,
  input  logic [63:0]  cfg_data_i,
  input  logic         done_i,
  input  logic [15:0]  temperature_tenths_i,
  input  logic [19:0]  pressure_pa_i,
  input  logic         divide_fault_i,
  output int           fail_count_o,
  output int           pending_o
);

  typedef struct packed {
    logic [15:0] temp;
    logic [19:0] pres;
    logic        fault;
  } reading_t;

  logic [63:0] cal_a, cal_b;
  logic [31:0] cal_c;
  logic [1:0]  oss;
  reading_t    expected_q[$];

  function automatic logic [31:0] ext16(logic [15:0] v);
    return {{16{v[15]}}, v};
  endfunction

  function automatic logic [31:0] sra(logic [31:0] v, int s);
    return 32'($signed(v) >>> s);
  endfunction

  function automatic logic [31:0] quot(logic [31:0] a, logic [31:0] b);
    logic [31:0] ma, mb, q;
    ma = a[31] ? -a : a;
    mb = b[31] ? -b : b;
    q  = ma / mb;
    return (a[31] != b[31]) ? -q : q;
  endfunction

  function automatic reading_t compensate(logic [15:0] ut16, logic [23:0] up24);
    reading_t r;
    logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md, ut, up;
    logic [31:0] x1, x2, x3, b3, b4, b5, b6, b7, p, sq, den, pres, t;
    r = '{temp: '0, pres: '0, fault: 1'b1};
    ac1 = ext16(cal_a[15:0]);  ac2 = ext16(cal_a[31:16]);
    ac3 = ext16(cal_a[47:32]); ac4 = {16'd0, cal_a[63:48]};
    ac5 = {16'd0, cal_b[15:0]}; ac6 = {16'd0, cal_b[31:16]};
    b1 = ext16(cal_b[47:32]);  b2 = ext16(cal_b[63:48]);
    mc = ext16(cal_c[15:0]);   md = ext16(cal_c[31:16]);
    ut = {16'd0, ut16};
    up = {8'd0, up24};
    x1  = sra((ut - ac6) * ac5, 15);
    den = x1 + md;
    if (den == 0) return r;
    x2 = quot(mc * 32'd2048, den);
    b5 = x1 + x2;
    t  = sra(b5 + 32'd8, 4);
    b6 = b5 - bpc_pkg::TempOffset;
    sq = sra(b6 * b6, 12);
    x3 = sra(b2 * sq, 11) + sra(ac2 * b6, 11);
    b3 = quot(((ac1 * 32'd4 + x3) << oss) + 32'd2, 32'd4);
    x3 = sra(sra(ac3 * b6, 13) + sra(b1 * sq, 16) + 32'd2, 2);
    b4 = (ac4 * (x3 + bpc_pkg::B4Bias)) >> 15;
    if (b4 == 0) return r;
    b7 = ((up >> (8 - oss)) - b3) * (bpc_pkg::PresScale >> oss);
    p  = !b7[31] ? (b7 * 32'd2) / b4 : (b7 / b4) * 32'd2;
    x1 = sra(p, 8);
    x1 = x1 * x1;
    x1 = sra(x1 * bpc_pkg::CoefSq, 16);
    x2 = sra(bpc_pkg::CoefLin * p, 16);
    pres = p + sra(x1 + x2 + bpc_pkg::CoefOff, 4);
    // saturate: temperature to s16, pressure to 0..PresMax
    if ($signed(t) > 32767) r.temp = 16'h7FFF;
    else if ($signed(t) < -32768) r.temp = 16'h8000;
    else r.temp = t[15:0];
    if (pres[31]) r.pres = '0;
    else if (pres > 32'(bpc_pkg::PresMax)) r.pres = bpc_pkg::PresMax;
    else r.pres = pres[19:0];
    r.fault = 1'b0;
    return r;
  endfunction

  assign pending_o = expected_q.size();

  always @(posedge clk_i or negedge rst_ni) begin
    reading_t exp_r;
    if (!rst_ni) begin
      cal_a <= '0; cal_b <= '0; cal_c <= '0; oss <= '0;
      fail_count_o <= 0;
      expected_q.delete();
    end else begin
      if (start_i && !busy_i)
        expected_q.push_back(compensate(raw_temperature_i, raw_pressure_i));
      if (done_i) begin
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected result temp=%0d pres=%0d fault=%0b", $time,
                   $signed(temperature_tenths_i), pressure_pa_i, divide_fault_i);
          fail_count_o <= fail_count_o + 1;
        end else begin
          exp_r = expected_q.pop_front();
          if (exp_r != {temperature_tenths_i, pressure_pa_i, divide_fault_i}) begin
            $display({"%0t: mismatch expected temp=%0d pres=%0d fault=%0b,",
                      " actual temp=%0d pres=%0d fault=%0b"},
                     $time, $signed(exp_r.temp), exp_r.pres, exp_r.fault,
                     $signed(temperature_tenths_i), pressure_pa_i, divide_fault_i);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
      // registers take effect for requests after the write edge
      if (cfg_valid_i && cfg_ready_i) begin
        case (bpc_pkg::cfg_idx_e'(cfg_index_i))
          bpc_pkg::CfgGroupA: cal_a <= cfg_data_i;
          bpc_pkg::CfgGroupB: cal_b <= cfg_data_i;
          bpc_pkg::CfgGroupC: cal_c <= cfg_data_i[31:0];
          bpc_pkg::CfgOss:    oss   <= cfg_data_i[1:0];
          default: ;
        endcase
      end
    end
  end
endmodule

/* test/tb_barometric_pressure_compensation.sv */
// Testbench top: drives requests and calibration writes, reports the verdict.
`timescale 1ns / 1ps
module tb_barometric_pressure_compensation;

  localparam int Latency  = 75;
  localparam int MaxCycle = 400000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start_i = 1'b0;
  logic        busy_o;
  logic [15:0] raw_temperature_i = '0;
  logic [23:0] raw_pressure_i = '0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i = '0;
  logic [63:0] cfg_data_i = '0;
  logic        done_o;
  logic signed [15:0] temperature_tenths_o;
  logic [19:0] pressure_pa_o;
  logic        divide_fault_o;
  int          fail_count, pending;
  int          cycle_count = 0;

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  barometric_pressure_compensation dut (.*);

  bpc_checker u_checker (
    .clk_i, .rst_ni, .start_i, .busy_i(busy_o), .raw_temperature_i, .raw_pressure_i,
    .cfg_valid_i, .cfg_ready_i(cfg_ready_o), .cfg_index_i, .cfg_data_i,
    .done_i(done_o), .temperature_tenths_i(temperature_tenths_o),
    .pressure_pa_i(pressure_pa_o), .divide_fault_i(divide_fault_o),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  // Watchdog on total run length.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > MaxCycle) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Write one calibration register; block must be idle.
  task automatic write_reg(bpc_pkg::cfg_idx_e idx, logic [63:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
  endtask

  // Wait until every expected result is back, plus drain margin.
  task automatic drain();
    start_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (Latency + 5) @(posedge clk_i);
  endtask

  // Issue one request; random idle before it unless steady.
  task automatic send_request(logic [15:0] ut, logic [23:0] up, bit steady);
    if (!steady) begin
      while ($urandom_range(99) < 22) begin
        start_i <= 1'b0;
        @(posedge clk_i);
      end
    end
    start_i <= 1'b1;
    raw_temperature_i <= ut;
    raw_pressure_i <= up;
    do @(posedge clk_i); while (busy_o);
  endtask

  // Calibration close to a real part's factory values, with random jitter.
  function automatic logic [63:0] jitter(logic [63:0] v, bit wild);
    return wild ? {$urandom, $urandom} : v ^ {4{4'h0, 12'($urandom_range(0, 63))}};
  endfunction

  initial begin
    logic [63:0] typ_a, typ_b;
    logic [31:0] typ_c;
    int phase;
    bit steady, wild;
    typ_a = {16'd32741, 16'hC795, 16'hFFBA, 16'd408};   // ac4 ac3 ac2 ac1
    typ_b = {16'hFF80 /*b2*/, 16'd6190, 16'd23153, 16'd32757};
    typ_c = {16'd2868, 16'hD4BD};                        // md, mc
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: reset calibration gives zero divisors -> fault.
    send_request(16'h0000, 24'h000000, 1'b1);
    send_request(16'hFFFF, 24'hFFFFFF, 1'b1);
    drain();
    write_reg(bpc_pkg::CfgGroupA, typ_a);
    write_reg(bpc_pkg::CfgGroupB, typ_b);
    write_reg(bpc_pkg::CfgGroupC, typ_c);
    write_reg(bpc_pkg::CfgOss, 64'd0);
    send_request(16'd27898, 24'd23843 << 8, 1'b1);
    send_request(16'h0000, 24'h000000, 1'b1);
    send_request(16'hFFFF, 24'hFFFFFF, 1'b1);
    send_request(16'h8000, 24'h800000, 1'b1);
    send_request(16'h7FFF, 24'h7FFFFF, 1'b1);
    drain();
    // Oversampling extremes.
    write_reg(bpc_pkg::CfgOss, 64'd3);
    send_request(16'd27898, 24'hFFFFFF, 1'b1);
    send_request(16'd27898, 24'h000000, 1'b1);
    drain();
    // md cancels x1 (ac5 = 0 -> x1 = 0, md = 0): temperature divisor zero.
    write_reg(bpc_pkg::CfgGroupB, {typ_b[63:16], 16'd0});
    write_reg(bpc_pkg::CfgGroupC, {16'd0, typ_c[15:0]});
    send_request(16'd1234, 24'd1234, 1'b1);
    drain();
    // ac4 = 0 -> pressure divisor zero; extreme coefficients for saturation.
    write_reg(bpc_pkg::CfgGroupA, {16'd0, typ_a[47:0]});
    write_reg(bpc_pkg::CfgGroupB, typ_b);
    write_reg(bpc_pkg::CfgGroupC, typ_c);
    send_request(16'd30000, 24'd5000000, 1'b1);
    drain();
    write_reg(bpc_pkg::CfgGroupA, {64{1'b1}});
    write_reg(bpc_pkg::CfgGroupB, {64{1'b1}});
    write_reg(bpc_pkg::CfgGroupC, {32'd0, 16'd1, 16'h8000});
    send_request(16'h0000, 24'hFFFFFF, 1'b1);
    send_request(16'hFFFF, 24'h000000, 1'b1);
    drain();
    // mc = md = -1 with ac5 = 0: divisor of -1, positive quotient.
    write_reg(bpc_pkg::CfgGroupB, {typ_b[63:16], 16'd0});
    write_reg(bpc_pkg::CfgGroupC, {32'd0, 16'hFFFF, 16'hFFFF});
    send_request(16'd100, 24'd100, 1'b1);
    drain();

    // Random phases; each drains (sender holds until all results are in).
    for (phase = 0; phase < 12; phase++) begin
      wild = (phase % 4 == 3);
      write_reg(bpc_pkg::CfgGroupA, jitter(typ_a, wild));
      write_reg(bpc_pkg::CfgGroupB, jitter(typ_b, wild));
      write_reg(bpc_pkg::CfgGroupC,
                {32'd0, wild ? 32'($urandom) : typ_c ^ {2{4'h0, 12'($urandom_range(0, 63))}}});
      write_reg(bpc_pkg::CfgOss, 64'($urandom_range(0, 3)));
      steady = (phase == 5);
      repeat (150) begin
        if ($urandom_range(9) < 8)
          send_request(16'($urandom_range(20000, 36000)),
                       24'($urandom_range(3000000, 6500000)), steady);
        else
          send_request(16'($urandom), 24'($urandom), steady);
      end
      drain();
    end

    if (fail_count == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end
endmodule
